FILE: hw/rtl/pfn_pkg.sv
// Shared types, constants and the permutation table of the fBm noise block.
package pfn_pkg;

    localparam int PFN_MAX_OCTAVES     = 8;
    localparam int PFN_COORD_FRAC_BITS = 16;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SEED        = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OCTAVES     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LACUNARITY  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PERSISTENCE = 4'd3;

    localparam logic [7:0]  RST_SEED        = 8'd0;
    localparam logic [3:0]  RST_OCTAVES     = 4'd1;
    localparam logic [15:0] RST_LACUNARITY  = 16'd8192;
    localparam logic [15:0] RST_PERSISTENCE = 16'd16384;

    // quotient bits of the normalizing divide
    localparam int QUOT_W = 17;

    typedef struct packed {
        logic ld_in;
        logic mul;
        logic hash1;
        logic hash2;
        logic grad;
        logic lerpx;
        logic lerpy;
        logic wt;
        logic acc;
        logic div_start;
        logic out_ld;
    } t_cmd;

    typedef struct packed {
        logic last_oct;
        logic div_done;
    } t_sts;

    localparam logic [7:0] PERM_TAB [256] = '{
        8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,
        8'd201,8'd95,8'd96,8'd53,8'd194,8'd233,8'd7,8'd225,
        8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
        8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,
        8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,8'd62,
        8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
        8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,
        8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,
        8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
        8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,
        8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,
        8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
        8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,
        8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,
        8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
        8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,
        8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,
        8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
        8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,
        8'd182,8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,
        8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
        8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,
        8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,
        8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
        8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,
        8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,
        8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
        8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,
        8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,
        8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
        8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,
        8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
    };

endpackage

FILE: hw/rtl/pfn_div.sv
// Bit-serial restoring divider for the amplitude normalization, with Q2.14 saturation.
module pfn_div #(
    parameter int TW = 57,
    parameter int SW = 36
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [TW-1:0] i_dividend,
    input  logic        [SW-1:0] i_sum,
    output logic                 o_done,
    output logic        [15:0]   o_quot
);
    import pfn_pkg::*;

    localparam int CW = $clog2(QUOT_W + 1);

    logic [TW-1:0]     r_rem, n_rem;
    logic [TW-1:0]     r_dsh, n_dsh;
    logic [QUOT_W-1:0] r_q, n_q;
    logic              r_neg, n_neg;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic              r_done, n_done;

    always_comb begin
        n_rem  = r_rem;
        n_dsh  = r_dsh;
        n_q    = r_q;
        n_neg  = r_neg;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        if (i_start) begin
            n_neg = i_dividend[TW-1];
            n_rem = i_dividend[TW-1] ? TW'(-i_dividend) : TW'(i_dividend);
            // divisor is 4*sum, aligned to the top quotient bit
            n_dsh = TW'(i_sum) << (QUOT_W + 1);
            n_q   = '0;
            n_cnt = CW'(QUOT_W);
        end else if (r_cnt != '0) begin
            if (r_rem >= r_dsh) begin
                n_rem = r_rem - r_dsh;
                n_q   = {r_q[QUOT_W-2:0], 1'b1};
            end else begin
                n_q   = {r_q[QUOT_W-2:0], 1'b0};
            end
            n_dsh  = r_dsh >> 1;
            n_cnt  = r_cnt - CW'(1);
            n_done = (r_cnt == CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_rem <= n_rem;
        r_dsh <= n_dsh;
        r_q   <= n_q;
        r_neg <= n_neg;
    end

    // magnitude never exceeds 32768: only the positive side can overflow
    always_comb begin
        if (r_neg)
            o_quot = 16'(-r_q);
        else if (r_q[QUOT_W-1:15] != '0)
            o_quot = 16'h7FFF;
        else
            o_quot = r_q[15:0];
    end

    assign o_done = r_done;

endmodule

FILE: hw/rtl/pfn_dp.sv
// Datapath: config registers, shared octave noise core, accumulators and result register.
module pfn_dp #(
    parameter int MAX_OCTAVES     = 8,
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pfn_pkg::t_cmd                     i_cmd,
    output pfn_pkg::t_sts                     o_sts,
    input  logic                              i_cfg_we,
    input  logic [pfn_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [pfn_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic signed [31:0]                i_x_coord,
    input  logic signed [31:0]                i_y_coord,
    output logic signed [15:0]                o_noise_value
);
    import pfn_pkg::*;

    localparam int OW = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
    localparam int AW = $clog2(MAX_OCTAVES + 1);
    localparam int SW = 32 + AW;
    localparam int TW = 53 + AW;
    localparam int F  = COORD_FRAC_BITS;
    localparam logic [4:0] MAX5 = 5'(MAX_OCTAVES);

    function automatic logic signed [19:0] grad(input logic [2:0] k,
                                                input logic signed [19:0] gx,
                                                input logic signed [19:0] gy);
        logic signed [19:0] a;
        logic signed [19:0] b;
        logic signed [19:0] r;
        a = k[2] ? gy : gx;
        b = k[2] ? gx : gy;
        r = k[0] ? -a : a;
        return k[1] ? (r - (b <<< 1)) : (r + (b <<< 1));
    endfunction

    function automatic logic signed [19:0] lerp(input logic signed [19:0] a,
                                                input logic signed [19:0] b,
                                                input logic [16:0] t);
        logic signed [20:0] d;
        logic signed [38:0] p;
        d = {b[19], b} - {a[19], a};
        p = d * $signed({1'b0, t});
        return a + 20'(p >>> 16);
    endfunction

    // configuration
    logic [7:0]  r_seed;
    logic [3:0]  r_oct_cnt;
    logic [15:0] r_lac;
    logic [15:0] r_pers;

    // per-sample state
    logic signed [31:0]    r_cx, r_cy;
    logic [31:0]           r_freq, r_amp;
    logic [SW-1:0]         r_sum;
    logic signed [TW-1:0]  r_total;
    logic [OW-1:0]         r_oct;

    // octave pipeline registers
    logic [7:0]            r_xi, r_yi, r_p0, r_p1;
    logic [7:0]            r_aa, r_ab, r_ba, r_bb;
    logic [15:0]           r_t   [2];
    logic [19:0]           r_tm  [2];
    logic [15:0]           r_tt  [2];
    logic [19:0]           r_inn [2];
    logic [15:0]           r_t3  [2];
    logic [16:0]           r_f   [2];
    logic signed [19:0]    r_g00, r_g10, r_g01, r_g11;
    logic signed [19:0]    r_x1, r_x2, r_nh;
    logic signed [52:0]    r_wp;
    logic signed [15:0]    r_out;

    logic signed [64:0] px, py;
    logic [7:0]         hx;
    logic signed [19:0] gx0, gx1, gy0, gy1;
    logic signed [19:0] nn;
    logic signed [20:0] ns;
    logic [47:0]        ap, fp;
    logic [4:0]         eff_cnt;
    logic [15:0]        quot;
    logic               div_done;

    assign px  = r_cx * $signed({1'b0, r_freq});
    assign py  = r_cy * $signed({1'b0, r_freq});
    assign hx  = r_xi + r_seed + 8'(r_oct);
    assign gx0 = $signed({4'b0, r_t[0]});
    assign gy0 = $signed({4'b0, r_t[1]});
    assign gx1 = gx0 - 20'sd65536;
    assign gy1 = gy0 - 20'sd65536;
    assign nn  = lerp(r_x1, r_x2, r_f[1]);
    assign ns  = {nn[19], nn} + 21'sd65536;
    assign ap  = r_amp * r_pers;
    assign fp  = r_freq * r_lac;

    always_comb begin
        if (r_oct_cnt == '0)
            eff_cnt = 5'd1;
        else if ({1'b0, r_oct_cnt} > MAX5)
            eff_cnt = MAX5;
        else
            eff_cnt = {1'b0, r_oct_cnt};
    end

    assign o_sts.last_oct = ((5'(r_oct) + 5'd1) == eff_cnt);
    assign o_sts.div_done = div_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed    <= RST_SEED;
            r_oct_cnt <= RST_OCTAVES;
            r_lac     <= RST_LACUNARITY;
            r_pers    <= RST_PERSISTENCE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SEED:        r_seed    <= i_cfg_data[7:0];
                CFG_OCTAVES:     r_oct_cnt <= i_cfg_data[3:0];
                CFG_LACUNARITY:  r_lac     <= i_cfg_data;
                CFG_PERSISTENCE: r_pers    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_in) begin
            r_cx    <= i_x_coord;
            r_cy    <= i_y_coord;
            r_freq  <= 32'h0001_0000;
            r_amp   <= 32'h0000_8000;
            r_sum   <= '0;
            r_total <= '0;
            r_oct   <= '0;
        end
        if (i_cmd.mul) begin
            r_xi   <= px[F+23:F+16];
            r_yi   <= py[F+23:F+16];
            r_t[0] <= px[F+15:F];
            r_t[1] <= py[F+15:F];
        end
        if (i_cmd.hash1) begin
            r_p0 <= PERM_TAB[hx];
            r_p1 <= PERM_TAB[hx + 8'd1];
            for (int k = 0; k < 2; k++) begin
                r_tm[k] <= 20'((36'(r_t[k]) *
                           36'(20'd983040 - 20'(r_t[k]) * 20'd6)) >> 16);
                r_tt[k] <= 16'((32'(r_t[k]) * 32'(r_t[k])) >> 16);
            end
        end
        if (i_cmd.hash2) begin
            r_aa <= PERM_TAB[r_p0 + r_yi];
            r_ab <= PERM_TAB[r_p0 + r_yi + 8'd1];
            r_ba <= PERM_TAB[r_p1 + r_yi];
            r_bb <= PERM_TAB[r_p1 + r_yi + 8'd1];
            for (int k = 0; k < 2; k++) begin
                r_inn[k] <= 20'd655360 - r_tm[k];
                r_t3[k]  <= 16'((32'(r_tt[k]) * 32'(r_t[k])) >> 16);
            end
        end
        if (i_cmd.grad) begin
            r_g00 <= grad(r_aa[2:0], gx0, gy0);
            r_g10 <= grad(r_ba[2:0], gx1, gy0);
            r_g01 <= grad(r_ab[2:0], gx0, gy1);
            r_g11 <= grad(r_bb[2:0], gx1, gy1);
            for (int k = 0; k < 2; k++) begin
                logic [35:0] fq;
                fq = 36'(r_t3[k]) * 36'(r_inn[k]);
                // fade clamps at 1.0
                r_f[k] <= (fq[35:16] > 20'd65536) ? 17'd65536 : fq[32:16];
            end
        end
        if (i_cmd.lerpx) begin
            r_x1 <= lerp(r_g00, r_g10, r_f[0]);
            r_x2 <= lerp(r_g01, r_g11, r_f[0]);
        end
        if (i_cmd.lerpy)
            r_nh <= ns[20:1];
        if (i_cmd.wt)
            r_wp <= r_nh * $signed({1'b0, r_amp});
        if (i_cmd.acc) begin
            r_total <= r_total + TW'(r_wp);
            r_sum   <= r_sum + SW'(r_amp);
            r_amp   <= ap[47] ? 32'hFFFF_FFFF : ap[46:15];
            r_freq  <= (fp[47:44] != '0) ? 32'hFFFF_FFFF : fp[43:12];
            r_oct   <= r_oct + OW'(1);
        end
        if (i_cmd.out_ld)
            r_out <= quot;
    end

    pfn_div #(
        .TW (TW),
        .SW (SW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_total),
        .i_sum      (r_sum),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    assign o_noise_value = r_out;

endmodule

FILE: hw/rtl/pfn_ctrl.sv
// Controller: sequences the octave steps, the divide and the output handshake.
module pfn_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_ready,
    output pfn_pkg::t_cmd o_cmd,
    input  pfn_pkg::t_sts i_sts
);
    import pfn_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL  = 4'd1;
    localparam logic [3:0] S_H1   = 4'd2;
    localparam logic [3:0] S_H2   = 4'd3;
    localparam logic [3:0] S_GRAD = 4'd4;
    localparam logic [3:0] S_LX   = 4'd5;
    localparam logic [3:0] S_LY   = 4'd6;
    localparam logic [3:0] S_WT   = 4'd7;
    localparam logic [3:0] S_ACC  = 4'd8;
    localparam logic [3:0] S_DST  = 4'd9;
    localparam logic [3:0] S_DIV  = 4'd10;
    localparam logic [3:0] S_FIN  = 4'd11;

    logic [3:0] r_state, n_state;
    logic       r_ov, n_ov;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.ld_in = i_valid;
                if (i_valid) n_state = S_MUL;
            end
            S_MUL: begin o_cmd.mul = 1'b1; n_state = S_H1; end
            S_H1:  begin o_cmd.hash1 = 1'b1; n_state = S_H2; end
            S_H2:  begin o_cmd.hash2 = 1'b1; n_state = S_GRAD; end
            S_GRAD: begin o_cmd.grad = 1'b1; n_state = S_LX; end
            S_LX:  begin o_cmd.lerpx = 1'b1; n_state = S_LY; end
            S_LY:  begin o_cmd.lerpy = 1'b1; n_state = S_WT; end
            S_WT:  begin o_cmd.wt = 1'b1; n_state = S_ACC; end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = i_sts.last_oct ? S_DST : S_MUL;
            end
            S_DST: begin o_cmd.div_start = 1'b1; n_state = S_DIV; end
            S_DIV: if (i_sts.div_done) n_state = S_FIN;
            S_FIN: begin
                // hold until the result register is free
                if (!r_ov || i_ready) begin
                    o_cmd.out_ld = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_ov = r_ov;
        if (r_ov && i_ready) n_ov = 1'b0;
        if (o_cmd.out_ld)    n_ov = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ov;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_ld |-> (!r_ov || i_ready))
        else $error("result overwritten while pending");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_MUL))
        else $error("accepted beat did not start octave work");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("more than one datapath command");

    a_div_to_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && i_sts.div_done) |=> (r_state == S_FIN))
        else $error("divide completion missed");

endmodule

FILE: hw/rtl/perlin_fbm_noise_2d.sv
// Top level of the fractal Brownian motion 2D gradient noise block.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+----------------------------------
//  sample   | in        | i_valid / o_ready    | i_x_coord, i_y_coord (Q16.16)
//  result   | out       | o_valid / i_ready    | o_noise_value (Q2.14, saturated)
//  config   | in        | i_cfg_we             | i_cfg_idx, i_cfg_data
//
// A sample beat runs each octave through the shared octave core (coordinate
// multiply, two permutation lookups, fade, gradients, two lerps, weight and
// accumulate), after a load step, and ends with the 17-step normalizing divider.
// One sample is worked on at a time.
// The result register lets a new sample beat be taken while the previous result
// still waits; a stalled result only holds the next one at its final step.
// Reset (i_rst_n low, synchronous) restores the config registers and idles the
// controller.
module perlin_fbm_noise_2d #(
    parameter int MAX_OCTAVES     = pfn_pkg::PFN_MAX_OCTAVES,
    parameter int COORD_FRAC_BITS = pfn_pkg::PFN_COORD_FRAC_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic signed [31:0]             i_x_coord,
    input  logic signed [31:0]             i_y_coord,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic signed [15:0]             o_noise_value,
    input  logic                           i_cfg_we,
    input  logic [pfn_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pfn_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import pfn_pkg::*;

    t_cmd cmd;
    t_sts sts;

    pfn_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    pfn_dp #(
        .MAX_OCTAVES     (MAX_OCTAVES),
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_x_coord     (i_x_coord),
        .i_y_coord     (i_y_coord),
        .o_noise_value (o_noise_value)
    );

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the fBm 2D gradient noise block.
module testbench;
    import pfn_pkg::*;

    // Scoreboard: keeps a shadow of the config registers, computes the expected
    // noise for each accepted sample beat and compares result beats in order.
    class FbmNoiseScoreboard;
        logic [7:0]  seed_q;
        logic [3:0]  octaves_q;
        logic [15:0] lacun_q;
        logic [15:0] persist_q;
        logic signed [15:0] expected_noise[$];

        function new();
            seed_q    = RST_SEED;
            octaves_q = RST_OCTAVES;
            lacun_q   = RST_LACUNARITY;
            persist_q = RST_PERSISTENCE;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SEED:        seed_q    = data[7:0];
                CFG_OCTAVES:     octaves_q = data[3:0];
                CFG_LACUNARITY:  lacun_q   = data;
                CFG_PERSISTENCE: persist_q = data;
                default: ;
            endcase
        endfunction

        // quintic fade, Q0.16 in, Q1.16 out clamped to 1.0
        function longint fade(longint t);
            longint m, inner, t2, t3, f;
            m     = 15 * 65536 - 6 * t;
            inner = 10 * 65536 - ((t * m) >> 16);
            t2    = (t * t) >> 16;
            t3    = (t2 * t) >> 16;
            f     = (t3 * inner) >> 16;
            if (f > 65536) f = 65536;
            return f;
        endfunction

        function longint grad(logic [7:0] h, longint gx, longint gy);
            longint a, b, r;
            a = (h[2] == 1'b0) ? gx : gy;
            b = (h[2] == 1'b0) ? gy : gx;
            r = h[0] ? -a : a;
            return r + (h[1] ? -2 * b : 2 * b);
        endfunction

        function longint lerp(longint a, longint b, longint t);
            return a + ((t * (b - a)) >>> 16);
        endfunction

        // one octave, returns (n+1)/2 in signed Q16
        function longint octave_noise(longint cx, longint cy, longint freq, logic [7:0] sd);
            logic [63:0] px, py;
            logic [7:0] xi, yi, p0, p1, aa, ab, ba, bb;
            longint xf, yf, u, v, x1, x2, n;
            px = cx * freq;
            py = cy * freq;
            xi = px[39:32];
            yi = py[39:32];
            xf = px[31:16];
            yf = py[31:16];
            u  = fade(xf);
            v  = fade(yf);
            p0 = PERM_TAB[8'(xi + sd)];
            p1 = PERM_TAB[8'(xi + 8'd1 + sd)];
            aa = PERM_TAB[8'(p0 + yi)];
            ab = PERM_TAB[8'(p0 + yi + 8'd1)];
            ba = PERM_TAB[8'(p1 + yi)];
            bb = PERM_TAB[8'(p1 + yi + 8'd1)];
            x1 = lerp(grad(aa, xf, yf), grad(ba, xf - 65536, yf), u);
            x2 = lerp(grad(ab, xf, yf - 65536), grad(bb, xf - 65536, yf - 65536), u);
            n  = lerp(x1, x2, v);
            return (n + 65536) >>> 1;
        endfunction

        function logic signed [15:0] fbm_predict(logic signed [31:0] x, logic signed [31:0] y);
            longint cx, cy, freq, amp, amp_sum, total, q;
            int count;
            cx = x;
            cy = y;
            freq = 65536;
            amp = 32768;
            amp_sum = 0;
            total = 0;
            count = octaves_q;
            if (count == 0) count = 1;
            if (count > PFN_MAX_OCTAVES) count = PFN_MAX_OCTAVES;
            for (int i = 0; i < count; i++) begin
                total += octave_noise(cx, cy, freq, 8'(seed_q + i)) * amp;
                amp_sum += amp;
                amp = (amp * persist_q) >> 15;
                if (amp > 64'hFFFF_FFFF) amp = 64'hFFFF_FFFF;
                freq = (freq * lacun_q) >> 12;
                if (freq > 64'hFFFF_FFFF) freq = 64'hFFFF_FFFF;
            end
            q = total / (amp_sum * 4);
            if (q > 32767) q = 32767;
            if (q < -32768) q = -32768;
            return q[15:0];
        endfunction

        function void note_sample(logic signed [31:0] x, logic signed [31:0] y);
            expected_noise.push_back(fbm_predict(x, y));
        endfunction

        // empty string when the beat matches
        function string check_result(logic signed [15:0] got);
            logic signed [15:0] want;
            if (expected_noise.size() == 0)
                return $sformatf("result %0d with nothing expected", got);
            want = expected_noise.pop_front();
            if (got !== want)
                return $sformatf("noise_value got %0d expected %0d", got, want);
            return "";
        endfunction

        function int pending();
            return expected_noise.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic signed [31:0]    i_x_coord;
    logic signed [31:0]    i_y_coord;
    logic                  o_valid;
    logic                  i_ready;
    logic signed [15:0]    o_noise_value;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    FbmNoiseScoreboard sb = new();
    int  mismatches = 0;
    bit  no_idle = 0;       // suppresses random gaps on both sides
    bit  hold_go = 0;       // asks the receiver for one long hold-off

    perlin_fbm_noise_2d u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_x_coord     (i_x_coord),
        .i_y_coord     (i_y_coord),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_noise_value (o_noise_value),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog: well beyond the slowest legal run (~600 beats).
    initial begin
        #8_000_000;
        $display("Some tests failed");
        $finish;
    end

    task automatic report(string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Result side: random back-pressure plus one long hold-off, counted here.
    initial begin
        bit held;
        held = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_go && !held) begin
                held = 1;
                i_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end
            i_ready <= no_idle || ($urandom_range(99) >= 11);
        end
    end

    // Result monitor: sampled at the edge, before any update of this step.
    always @(posedge i_clk) begin
        string msg;
        if (i_rst_n && o_valid && i_ready) begin
            msg = sb.check_result(o_noise_value);
            if (msg != "") report(msg);
        end
    end

    // Sample beat: optional random gap, then hold valid until accepted.
    task automatic send_sample(logic signed [31:0] x, logic signed [31:0] y);
        while (!no_idle && $urandom_range(99) < 11) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_x_coord <= x;
        i_y_coord <= y;
        do @(posedge i_clk); while (!o_ready);
        sb.note_sample(x, y);
    endtask

    // Leaves the write enable high; the caller drops it after its last write.
    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    // Block is idle once valid is down and all results are back.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() > 0) @(posedge i_clk);
    endtask

    task automatic set_cfg(int sd, int oc, int lac, int per);
        write_cfg(CFG_SEED, 16'(sd));
        write_cfg(CFG_OCTAVES, 16'(oc));
        write_cfg(CFG_LACUNARITY, 16'(lac));
        write_cfg(CFG_PERSISTENCE, 16'(per));
        i_cfg_we <= 1'b0;
    endtask

    // Mostly moderate coordinates (+-128.0) that exercise the lattice wrap,
    // the rest fully random so every coordinate bit toggles.
    task automatic random_samples(int count);
        logic signed [31:0] x, y;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(9) < 4) begin
                x = $urandom;
                y = $urandom;
            end else begin
                x = $signed($urandom_range(32'h00FF_FFFF)) - 32'sh0080_0000;
                y = $signed($urandom_range(32'h00FF_FFFF)) - 32'sh0080_0000;
            end
            send_sample(x, y);
        end
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_x_coord  <= '0;
        i_y_coord  <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset config, coordinate extremes, fraction and wrap edges.
        send_sample(32'sh0000_0000, 32'sh0000_0000);
        send_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_sample(32'sh8000_0000, 32'sh8000_0000);
        send_sample(32'sh7FFF_FFFF, 32'sh8000_0000);
        send_sample(32'shFFFF_FFFF, 32'sh0000_0001);
        send_sample(32'sh0000_FFFF, 32'sh0000_8000);
        send_sample(32'sh00FF_8000, 32'sh0100_4000);
        send_sample(32'shFF00_C000, 32'shFFFF_0001);
        drain();

        // Zero octave count acts as one; seed wrap with max octaves.
        set_cfg(255, 0, 8192, 16384);
        send_sample(32'sh0003_2000, 32'shFFFA_7000);
        drain();
        set_cfg(16'hFFFF, 15, 65535, 65535);   // count clamps to max, freq saturates
        send_sample(32'sh7FFF_FFFF, 32'sh0001_0000);
        send_sample(32'sh8000_0000, 32'shFFFF_FFFF);
        send_sample(32'sh0012_3456, 32'shFFED_CBAA);
        drain();
        set_cfg(0, 8, 0, 0);                   // lacunarity and persistence zero
        send_sample(32'sh0004_8000, 32'sh0002_4000);
        send_sample(32'shFFF0_0001, 32'sh000F_FFFF);
        drain();
        // Writes beyond the register list are ignored.
        for (int r = 4; r < (1 << CFG_IDX_W); r++)
            write_cfg(CFG_IDX_W'(r), 16'hFFFF);
        i_cfg_we <= 1'b0;
        send_sample(32'sh0001_8000, 32'sh0000_4000);
        drain();

        // Random phases over a spread of settings.
        set_cfg(17, 4, 8192, 16384);
        random_samples(60);
        drain();

        // Long receiver hold-off while samples keep coming: result path fills.
        hold_go = 1;
        set_cfg(200, 8, 4096 + 1234, 40000);
        random_samples(60);
        drain();

        // Stretch with no gaps on either side.
        no_idle = 1;
        set_cfg(1, 2, 12288, 32768);
        random_samples(60);
        drain();
        no_idle = 0;

        set_cfg(128, 1, 8192, 16384);
        random_samples(60);
        drain();
        set_cfg(254, 8, 65535, 65535);
        random_samples(40);
        drain();
        set_cfg(77, 6, 1, 1);
        random_samples(40);
        drain();
        for (int ph = 0; ph < 6; ph++) begin
            set_cfg($urandom_range(65535), $urandom_range(15),
                    $urandom_range(65535), $urandom_range(65535));
            random_samples(30);
            drain();
        end

        repeat (150) @(posedge i_clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
